// File: design/tisp_pkg.sv
// ----------------------------------------------------------------------------
// tisp_pkg: shared definitions for the trie insert/search block
// Opcodes, fixed field widths and the control bundle that drives the node store.
// ----------------------------------------------------------------------------
`default_nettype none

package tisp_pkg;

  localparam int IN_OPCODE_W = 2;
  localparam int IN_LETTER_W = 5;

  localparam logic [IN_OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [IN_OPCODE_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [IN_OPCODE_W-1:0] OP_PREFIX = 2'd2;

  // Per-cycle requests to the link and mark memories
  typedef struct packed {
    logic link_re;
    logic link_we;
    logic mark_re;
    logic mark_we;
    logic mark_wdata;
  } mem_ctl_t;

endpackage : tisp_pkg

`default_nettype wire

// File: design/tisp_store.sv
// ----------------------------------------------------------------------------
// tisp_store: node store of the trie
// Child link memory and word-end mark memory, both with registered reads,
// plus the clearing sweep that zeroes them after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tisp_store #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire tisp_pkg::mem_ctl_t                  ctl,
  input  wire [$clog2(NODE_COUNT*ALPHABET_SIZE)-1:0] link_addr,
  input  wire [$clog2(NODE_COUNT)-1:0]             link_wdata,
  output logic [$clog2(NODE_COUNT)-1:0]            link_rdata,
  input  wire [$clog2(NODE_COUNT)-1:0]             mark_addr,
  output logic                                     mark_rdata,
  output logic                                     clr_busy
);
  import tisp_pkg::*;

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int SLOT_COUNT = NODE_COUNT * ALPHABET_SIZE;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  logic [NODE_W-1:0] link_mem [SLOT_COUNT];
  logic              mark_mem [NODE_COUNT];

  logic              clr_busy_r, clr_busy_nxt;
  logic [SLOT_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic              link_we;
  logic [SLOT_W-1:0] link_waddr;
  logic [NODE_W-1:0] link_wd;
  logic              mark_we;
  logic [NODE_W-1:0] mark_waddr;
  logic              mark_wd;

  // Sweep one link slot per cycle; marks ride along for the first NODE_COUNT
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + SLOT_W'(1);
      if (clr_cnt_r == SLOT_W'(SLOT_COUNT - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  assign link_we    = clr_busy_r | ctl.link_we;
  assign link_waddr = clr_busy_r ? clr_cnt_r : link_addr;
  assign link_wd    = clr_busy_r ? '0 : link_wdata;

  assign mark_we    = (clr_busy_r && (clr_cnt_r < SLOT_W'(NODE_COUNT))) | ctl.mark_we;
  assign mark_waddr = clr_busy_r ? clr_cnt_r[NODE_W-1:0] : mark_addr;
  assign mark_wd    = clr_busy_r ? 1'b0 : ctl.mark_wdata;

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wd;
    end
    if (ctl.link_re) begin
      link_rdata <= link_mem[link_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wd;
    end
    if (ctl.mark_re) begin
      mark_rdata <= mark_mem[mark_addr];
    end
  end

  assign clr_busy = clr_busy_r;

endmodule : tisp_store

`default_nettype wire

// File: design/trie_insert_search_prefix.sv
// ----------------------------------------------------------------------------
// trie_insert_search_prefix: letter-serial trie with insert, exact and prefix search
// Walks a trie kept in a fixed node pool, one letter item at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive start with in_opcode, in_letter and in_last_letter;
//   the item is taken at a rising edge where start is high and busy is low.
//   A word is a run of letter items ending with in_last_letter high; the
//   opcode of its first letter (insert, exact search, prefix search) holds
//   for the whole word.
//   Result channel: one item per word, shown for exactly one cycle on
//   out_hit / out_pool_overflow with out_valid high. The receiver cannot
//   stall; a result is never held.
//   Pacing: each letter waits on the child link read (synchronous memory),
//   and busy stays high until it is back, so a new letter is taken only
//   after it. The last letter of an exact search also waits for the
//   word-end mark, read from its own memory after the final link is known.
//   Result timing: out_valid is registered from the ST_LINK state of the last
//   letter, or from ST_MARK after it for an exact search.
//   Reset: rst_n low clears the walk state and the node allocator. After
//   reset the link and mark memories are swept to zero, one link slot per
//   cycle, over all NODE_COUNT*ALPHABET_SIZE slots (26624 at the defaults);
//   busy stays high until the sweep ends.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_insert_search_prefix #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire [tisp_pkg::IN_OPCODE_W-1:0]  in_opcode,
  input  wire [tisp_pkg::IN_LETTER_W-1:0]  in_letter,
  input  wire                              in_last_letter,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic                             out_pool_overflow
);
  import tisp_pkg::*;

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = $clog2(NODE_COUNT + 1);
  localparam int SLOT_W     = $clog2(NODE_COUNT * ALPHABET_SIZE);
  localparam int ALPHA_CW   = $clog2(ALPHABET_SIZE + 1);
  localparam int CMP_W      = (ALPHA_CW > IN_LETTER_W) ? ALPHA_CW : IN_LETTER_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LINK = 3'b010,
    ST_MARK = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [IN_OPCODE_W-1:0] op_r, op_nxt;
  logic [NODE_W-1:0]      pos_r, pos_nxt;
  logic                   failed_r, failed_nxt;
  logic                   inside_r, inside_nxt;
  logic [FREE_W-1:0]      free_r, free_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic                   last_r, last_nxt;
  logic                   walk_r, walk_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_hit_r, out_hit_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic                   accept;
  logic                   clr_busy;
  logic [IN_OPCODE_W-1:0] op_eff;
  logic [NODE_W-1:0]      pos_eff;
  logic                   failed_eff;
  logic                   op_ok;
  logic                   letter_ok;
  logic                   walk_now;
  logic [SLOT_W-1:0]      slot_now;

  mem_ctl_t               ctl;
  logic [SLOT_W-1:0]      link_addr;
  logic [NODE_W-1:0]      link_wdata;
  logic [NODE_W-1:0]      link_rdata;
  logic [NODE_W-1:0]      mark_addr;
  logic                   mark_rdata;

  assign busy   = clr_busy | (state_r != ST_IDLE);
  assign accept = start & ~busy;

  // A new word starts at the root with its own opcode; inside a word keep the walk
  assign op_eff     = inside_r ? op_r : in_opcode;
  assign pos_eff    = inside_r ? pos_r : '0;
  assign failed_eff = inside_r & failed_r;
  assign op_ok      = (op_eff == OP_INSERT) || (op_eff == OP_SEARCH) ||
                      (op_eff == OP_PREFIX);
  assign letter_ok  = CMP_W'(in_letter) < CMP_W'(ALPHABET_SIZE);
  assign walk_now   = ~failed_eff & op_ok & letter_ok;
  assign slot_now   = SLOT_W'(pos_eff) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(in_letter);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    failed_nxt    = failed_r;
    inside_nxt    = inside_r;
    free_nxt      = free_r;
    slot_nxt      = slot_r;
    last_nxt      = last_r;
    walk_nxt      = walk_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = out_hit_r;
    out_ovf_nxt   = out_ovf_r;
    ctl           = '0;
    link_addr     = slot_r;
    link_wdata    = NODE_W'(free_r);
    mark_addr     = pos_r;

    case (state_r)
      ST_IDLE: begin
        link_addr = slot_now;
        if (accept) begin
          ctl.link_re = walk_now;
          op_nxt      = op_eff;
          pos_nxt     = pos_eff;
          // letter outside the alphabet: a link that can never exist
          failed_nxt  = failed_eff | (~failed_eff & op_ok & ~letter_ok);
          inside_nxt  = 1'b1;
          slot_nxt    = slot_now;
          last_nxt    = in_last_letter;
          walk_nxt    = walk_now;
          state_nxt   = ST_LINK;
        end
      end

      ST_LINK: begin
        if (walk_r) begin
          if (link_rdata == '0) begin
            if ((op_r == OP_INSERT) && (free_r < FREE_W'(NODE_COUNT))) begin
              // allocate the next node from the bump counter
              ctl.link_we = 1'b1;
              pos_nxt     = NODE_W'(free_r);
              free_nxt    = free_r + FREE_W'(1);
            end else begin
              failed_nxt = 1'b1;
            end
          end else begin
            pos_nxt = link_rdata;
          end
        end
        mark_addr = pos_nxt;
        state_nxt = ST_IDLE;
        if (last_r) begin
          inside_nxt = 1'b0;
          case (op_r)
            OP_INSERT: begin
              ctl.mark_we    = ~failed_nxt;
              ctl.mark_wdata = 1'b1;
              out_valid_nxt  = 1'b1;
              out_hit_nxt    = ~failed_nxt;
              out_ovf_nxt    = failed_nxt;
            end
            OP_SEARCH: begin
              ctl.mark_re = ~failed_nxt;
              state_nxt   = ST_MARK;
            end
            OP_PREFIX: begin
              out_valid_nxt = 1'b1;
              out_hit_nxt   = ~failed_nxt;
              out_ovf_nxt   = 1'b0;
            end
            default: begin
              // unknown opcode walks nothing and always misses
              out_valid_nxt = 1'b1;
              out_hit_nxt   = 1'b0;
              out_ovf_nxt   = 1'b0;
            end
          endcase
        end
      end

      ST_MARK: begin
        out_valid_nxt = 1'b1;
        out_hit_nxt   = ~failed_r & mark_rdata;
        out_ovf_nxt   = 1'b0;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_INSERT;
      pos_r       <= '0;
      failed_r    <= 1'b0;
      inside_r    <= 1'b0;
      free_r      <= FREE_W'(1);
      last_r      <= 1'b0;
      walk_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      pos_r       <= pos_nxt;
      failed_r    <= failed_nxt;
      inside_r    <= inside_nxt;
      free_r      <= free_nxt;
      last_r      <= last_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    out_hit_r <= out_hit_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  tisp_store #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .link_addr  (link_addr),
    .link_wdata (link_wdata),
    .link_rdata (link_rdata),
    .mark_addr  (mark_addr),
    .mark_rdata (mark_rdata),
    .clr_busy   (clr_busy)
  );

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_pool_overflow = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_no_back_to_back_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe high on two cycles in a row");

  a_free_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (free_r >= FREE_W'(1)) && (free_r <= FREE_W'(NODE_COUNT)))
    else $error("node allocator out of range");

  a_hit_excludes_ovf : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_ovf_r))
    else $error("result reports both hit and overflow");

  a_link_write_in_walk : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.link_we |-> ((state_r == ST_LINK) && walk_r && (op_r == OP_INSERT) && !clr_busy))
    else $error("link write outside an insert walk");
`endif

endmodule : trie_insert_search_prefix

`default_nettype wire

// File: dv/trie_insert_search_prefix_tb.sv
// ----------------------------------------------------------------------------
// trie_insert_search_prefix_tb: self-checking bench for the letter-serial trie
// Sends words one letter item at a time and predicts every word result with a
// local copy of the trie. A short list of directed items covers the empty
// tree, the alphabet edges, bad letters and the unknown opcode. Random words
// follow, most of them built from stored words, then a fill pass that runs
// the node pool dry.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_insert_search_prefix_tb;
  import tisp_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int NODES          = 1024;
  localparam int ALPHA          = 26;
  localparam int TOP_LETTER     = (1 << IN_LETTER_W) - 1;
  localparam int WORD_MAX       = 24;
  localparam int BANK_SIZE      = 64;
  localparam int DRAIN_CYCLES   = 8;
  // The reset sweep alone keeps busy high while it clears all NODES*ALPHA slots.
  localparam int QUIET_LIMIT    = 4 * NODES * ALPHA;
  localparam int WARMUP_LETTERS = 100;
  localparam int CLOSING_LETTERS = 50;

  // Opcode 3 has no name in the package; the block answers it with a miss.
  localparam logic [IN_OPCODE_W-1:0] OP_UNKNOWN = 2'd3;

  localparam logic [IN_LETTER_W-1:0] L_A = 5'd0;
  localparam logic [IN_LETTER_W-1:0] L_B = 5'd1;
  localparam logic [IN_LETTER_W-1:0] L_C = 5'd2;
  localparam logic [IN_LETTER_W-1:0] L_D = 5'd3;
  localparam logic [IN_LETTER_W-1:0] L_F = 5'd5;
  localparam logic [IN_LETTER_W-1:0] L_H = 5'd7;
  localparam logic [IN_LETTER_W-1:0] L_Z = 5'd25;

  typedef struct packed {
    bit hit;
    bit ovf;
  } answer_t;

  typedef struct packed {
    logic [IN_OPCODE_W-1:0] op;
    logic [IN_LETTER_W-1:0] ltr;
    bit                     lst;
    bit                     typed;  // expected answer given in the row
    bit                     hit;
    bit                     ovf;
  } script_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [IN_OPCODE_W-1:0] in_opcode;
  logic [IN_LETTER_W-1:0] in_letter;
  logic                   in_last_letter;
  logic                   out_valid;
  logic                   out_hit;
  logic                   out_pool_overflow;

  trie_insert_search_prefix #(
    .NODE_COUNT    (NODES),
    .ALPHABET_SIZE (ALPHA)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_letter         (in_letter),
    .in_last_letter    (in_last_letter),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_pool_overflow (out_pool_overflow)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Trie shadow: links, word marks and the walk of the word in flight
  // --------------------------------------------------------------------------
  bit [9:0]               trie_link [NODES*ALPHA];
  bit                     word_mark [NODES];
  bit [9:0]               walk_node;
  bit [10:0]              free_node = 11'd1;
  bit                     walk_dead;
  bit [IN_OPCODE_W-1:0]   word_op;
  bit                     in_word;

  answer_t                pending_answers [$];
  int                     fail_count;
  int                     letters_sent;
  int                     quiet_cycles;
  bit                     idle_on;

  // Scratch word for the random part, plus a bank of inserted words to
  // search for, cut short, extend or alter.
  bit [4:0]               word_buf [WORD_MAX];
  int                     word_len;
  bit [4:0]               bank_letters [BANK_SIZE][WORD_MAX];
  int                     bank_len [BANK_SIZE];
  int                     bank_count;

  script_row_t            script [$];

  // Advance the shadow trie by one letter item; flag a word result at the
  // last letter.
  function automatic void trie_take(input logic [IN_OPCODE_W-1:0] op,
                                    input logic [IN_LETTER_W-1:0] ltr,
                                    input bit lst,
                                    output bit answered, output answer_t ans);
    int slot;
    answered = 1'b0;
    ans      = '0;
    // The first letter fixes the operation for the whole word.
    if (!in_word) begin
      word_op   = op;
      walk_node = '0;
      walk_dead = 1'b0;
      in_word   = 1'b1;
    end
    if (!walk_dead && word_op <= OP_PREFIX) begin
      if (ltr >= ALPHA) begin
        // Outside the alphabet: a link that can never exist.
        walk_dead = 1'b1;
      end else begin
        slot = walk_node * ALPHA + ltr;
        if (trie_link[slot] != '0) begin
          walk_node = trie_link[slot];
        end else if (word_op != OP_INSERT || free_node >= NODES) begin
          walk_dead = 1'b1;
        end else begin
          trie_link[slot] = free_node[9:0];
          walk_node       = free_node[9:0];
          free_node       = free_node + 1'b1;
        end
      end
    end
    if (lst) begin
      answered = 1'b1;
      case (word_op)
        OP_INSERT: begin
          if (!walk_dead) begin
            word_mark[walk_node] = 1'b1;
            ans.hit = 1'b1;
          end else begin
            ans.ovf = 1'b1;
          end
        end
        OP_SEARCH: ans.hit = !walk_dead && word_mark[walk_node];
        OP_PREFIX: ans.hit = !walk_dead;
        default: ;
      endcase
      in_word = 1'b0;
    end
  endfunction

  // Mostly letters of the alphabet, now and then one past its end, up to TOP_LETTER.
  function automatic bit [4:0] pick_letter(input bit narrow);
    if ($urandom_range(0, 99) < 3)
      return IN_LETTER_W'($urandom_range(ALPHA, TOP_LETTER));
    return IN_LETTER_W'($urandom_range(0, narrow ? 3 : ALPHA - 1));
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Enter and leave at a falling edge; start stays high between
  // back-to-back items and drops only for an idle burst.
  // --------------------------------------------------------------------------
  task automatic send_letter(input logic [IN_OPCODE_W-1:0] op,
                             input logic [IN_LETTER_W-1:0] ltr,
                             input bit lst, input bit typed,
                             input bit t_hit, input bit t_ovf);
    int      gap;
    bit      answered;
    answer_t ans;
    if (idle_on && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 19);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_letter      <= ltr;
    in_last_letter <= lst;
    // Hold the item until busy is low at a rising edge.
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    trie_take(op, ltr, lst, answered, ans);
    if (answered) begin
      if (typed) begin
        ans.hit = t_hit;
        ans.ovf = t_ovf;
      end
      pending_answers.push_back(ans);
    end
    letters_sent++;
    @(negedge clk);
  endtask

  // Send word_buf; opcodes after the first letter are don't-care, so scramble them.
  task automatic send_word(input logic [IN_OPCODE_W-1:0] op);
    int                     pos;
    logic [IN_OPCODE_W-1:0] tag;
    for (pos = 0; pos < word_len; pos++) begin
      if (pos == 0) tag = op;
      else tag = IN_OPCODE_W'($urandom_range(0, 3));
      send_letter(tag, word_buf[pos], pos == word_len - 1, 1'b0, 1'b0, 1'b0);
    end
  endtask

  task automatic remember_word();
    int slot;
    int pos;
    if (bank_count < BANK_SIZE) begin
      slot = bank_count;
      bank_count++;
    end else begin
      slot = $urandom_range(0, BANK_SIZE - 1);
    end
    bank_len[slot] = word_len;
    for (pos = 0; pos < word_len; pos++) bank_letters[slot][pos] = word_buf[pos];
  endtask

  // Build either a fresh word or a variant of a stored one into word_buf.
  task automatic build_word(input logic [IN_OPCODE_W-1:0] op);
    int pick;
    int src;
    int top;
    int pos;
    bit narrow;
    pick = $urandom_range(0, 99);
    if (bank_count == 0 || (op == OP_INSERT ? pick < 60 : pick < 30)) begin
      // A narrow alphabet makes fresh words collide with stored paths.
      word_len = $urandom_range(1, 8);
      narrow   = 1'($urandom_range(0, 1));
      for (pos = 0; pos < word_len; pos++) word_buf[pos] = pick_letter(narrow);
    end else begin
      src      = $urandom_range(0, bank_count - 1);
      word_len = bank_len[src];
      for (pos = 0; pos < word_len; pos++) word_buf[pos] = bank_letters[src][pos];
      case ($urandom_range(0, 3))
        0: ;  // the stored word as is
        1: word_len = $urandom_range(1, word_len);
        2: begin
          top = word_len + $urandom_range(1, 2);
          if (top > WORD_MAX) top = WORD_MAX;
          for (pos = word_len; pos < top; pos++) word_buf[pos] = pick_letter(1'b0);
          word_len = top;
        end
        default: word_buf[$urandom_range(0, word_len - 1)] = pick_letter(1'b0);
      endcase
    end
  endtask

  task automatic random_word();
    int                     pick;
    logic [IN_OPCODE_W-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_INSERT;
    else if (pick < 65) op = OP_SEARCH;
    else if (pick < 90) op = OP_PREFIX;
    else op = OP_UNKNOWN;
    build_word(op);
    send_word(op);
    if (op == OP_INSERT) remember_word();
  endtask

  // Hold off new items until every word result has come back.
  task automatic wait_for_answers();
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  function automatic script_row_t row(input logic [IN_OPCODE_W-1:0] op,
                                      input logic [IN_LETTER_W-1:0] ltr,
                                      input bit lst, input bit typed,
                                      input bit hit, input bit ovf);
    script_row_t r;
    r.op    = op;
    r.ltr   = ltr;
    r.lst   = lst;
    r.typed = typed;
    r.hit   = hit;
    r.ovf   = ovf;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest expected answer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result hit=%0b pool_overflow=%0b",
                 $time, out_hit, out_pool_overflow);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b, got %0b", $time, want.hit, out_hit);
          fail_count++;
        end
        if (out_pool_overflow !== want.ovf) begin
          $display("%0t: pool_overflow mismatch, expected %0b, got %0b",
                   $time, want.ovf, out_pool_overflow);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run after too long without an item or a result.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    script_row_t r;
    int          idx;
    int          pos;
    int          stop_at;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_opcode      = OP_INSERT;
    in_letter      = '0;
    in_last_letter = 1'b0;
    quiet_cycles   = 0;
    idle_on        = 1'b1;

    // Empty tree: nothing is found, the first insert lands.
    script.push_back(row(OP_SEARCH,  L_A,   1'b1, 1'b1, 1'b0, 1'b0));
    script.push_back(row(OP_PREFIX,  L_Z,   1'b1, 1'b1, 1'b0, 1'b0));
    script.push_back(row(OP_INSERT,  L_Z,   1'b1, 1'b1, 1'b1, 1'b0));
    script.push_back(row(OP_SEARCH,  L_Z,   1'b1, 1'b1, 1'b1, 1'b0));
    // Letters past the alphabet: insert fails as if the pool were full.
    script.push_back(row(OP_INSERT,  5'd31, 1'b1, 1'b1, 1'b0, 1'b1));
    script.push_back(row(OP_SEARCH,  5'd26, 1'b1, 1'b1, 1'b0, 1'b0));
    // Unknown opcode on the first letter rules the word, later opcodes don't.
    script.push_back(row(OP_UNKNOWN, L_F,   1'b0, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_INSERT,  L_H,   1'b1, 1'b1, 1'b0, 1'b0));
    // Insert "abc" with scrambled opcodes on the tail letters.
    script.push_back(row(OP_INSERT,  L_A,   1'b0, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_SEARCH,  L_B,   1'b0, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_PREFIX,  L_C,   1'b1, 1'b0, 1'b0, 1'b0));
    // Prefix "ab" exists; word "ab" does not; word "abc" does; "abd" is absent.
    script.push_back(row(OP_PREFIX,  L_A,   1'b0, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_PREFIX,  L_B,   1'b1, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_SEARCH,  L_A,   1'b0, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_SEARCH,  L_B,   1'b1, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_SEARCH,  L_A,   1'b0, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_SEARCH,  L_B,   1'b0, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_SEARCH,  L_C,   1'b1, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_PREFIX,  L_A,   1'b0, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_PREFIX,  L_B,   1'b0, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_PREFIX,  L_D,   1'b1, 1'b0, 1'b0, 1'b0));
    // Bad letter in the middle of an insert: fails with overflow.
    script.push_back(row(OP_INSERT,  L_A,   1'b0, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_INSERT,  L_B,   1'b0, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_INSERT,  5'd30, 1'b0, 1'b0, 1'b0, 1'b0));
    script.push_back(row(OP_INSERT,  L_C,   1'b1, 1'b1, 1'b0, 1'b1));

    // Hold reset, then release it at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed rows; the first item waits out the clearing sweep.
    for (idx = 0; idx < script.size(); idx++) begin
      r = script[idx];
      send_letter(r.op, r.ltr, r.lst, r.typed, r.hit, r.ovf);
    end

    // Random words until WARMUP_LETTERS letters are sent; flip idling in stretches.
    while (letters_sent < WARMUP_LETTERS) begin
      if ($urandom_range(0, 29) == 0) idle_on = !idle_on;
      random_word();
    end

    // Pause until all answers are back before draining the pool.
    start <= 1'b0;
    wait_for_answers();
    @(negedge clk);

    // Fill the pool with long fresh inserts until no free node is left.
    idle_on = 1'b1;
    while (free_node < NODES) begin
      if ($urandom_range(0, 29) == 0) idle_on = !idle_on;
      word_len = $urandom_range(10, 20);
      for (pos = 0; pos < word_len; pos++) begin
        word_buf[pos] = IN_LETTER_W'($urandom_range(0, ALPHA - 1));
      end
      send_word(OP_INSERT);
      remember_word();
    end

    // Closing stretch on a full pool, no idling.
    idle_on = 1'b0;
    stop_at = letters_sent + CLOSING_LETTERS;
    while (letters_sent < stop_at) random_word();

    start <= 1'b0;
    wait_for_answers();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
